FILE: rtl/core/htok_pkg.sv
// package for the http request tokenizer
// field kinds, status codes, parse phases and the result item type; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package htok_pkg;

  // default header limit
  localparam int unsigned MaxHeadersDef = 16;

  // delimiter bytes
  localparam logic [7:0] ChCr    = 8'd13;
  localparam logic [7:0] ChSp    = 8'd32;
  localparam logic [7:0] ChColon = 8'd58;

  typedef enum logic [2:0] {
    KindMethod  = 3'd0,
    KindPath    = 3'd1,
    KindVersion = 3'd2,
    KindName    = 3'd3,
    KindValue   = 3'd4,
    KindBody    = 3'd5,
    KindDone    = 3'd6
  } kind_e;

  typedef enum logic [2:0] {
    StatOk        = 3'd0,
    StatNoSpace   = 3'd1,
    StatNoColon   = 3'd2,
    StatTooMany   = 3'd3,
    StatEarlyEnd  = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    PhMethod  = 4'd0,
    PhPath    = 4'd1,
    PhVersion = 4'd2,
    PhLfLine  = 4'd3,
    PhName    = 4'd4,
    PhSkipSep = 4'd5,
    PhValue   = 4'd6,
    PhDiscard = 4'd7,
    PhLfBody  = 4'd8,
    PhBody    = 4'd9
  } phase_e;

  // one result item
  typedef struct packed {
    logic [2:0] field_kind;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       field_end;
    logic [3:0] header_index;
    logic [4:0] header_total;
    logic [2:0] parse_status;
    logic       request_end;
  } result_t;

endpackage

`default_nettype wire

FILE: rtl/core/htok_in_if.sv
// input channel of the tokenizer: one request byte per item
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

interface htok_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_buffer;

  modport source (output valid, output data_byte, output end_of_buffer, input ready);
  modport sink   (input valid, input data_byte, input end_of_buffer, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/htok_out_if.sv
// output channel of the tokenizer: one tagged result per item
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

interface htok_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] field_kind;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       field_end;
  logic [3:0] header_index;
  logic [4:0] header_total;
  logic [2:0] parse_status;
  logic       request_end;

  modport source (output valid, output field_kind, output out_byte, output byte_valid,
                  output field_end, output header_index, output header_total,
                  output parse_status, output request_end, input ready);
  modport sink   (input valid, input field_kind, input out_byte, input byte_valid,
                  input field_end, input header_index, input header_total,
                  input parse_status, input request_end, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/htok_in_stage.sv
// input register of the tokenizer
// depends on htok_in_if
`timescale 1ns / 1ps
`default_nettype none

module htok_in_stage (
  input  wire        clk_i,
  input  wire        rst_ni,
  htok_in_if.sink    in_i,
  input  wire        advance_i,
  output logic       valid_o,
  output logic [7:0] data_o,
  output logic       eob_o
);

  logic       valid_q;
  logic [7:0] data_q;
  logic       eob_q;

  // take a new item when empty or when the held one moves on
  assign in_i.ready = !valid_q || advance_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_i.ready) begin
      valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      data_q <= in_i.data_byte;
      eob_q  <= in_i.end_of_buffer;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;
  assign eob_o   = eob_q;

endmodule

`default_nettype wire

FILE: rtl/core/htok_parser.sv
// parse state and per-byte tagging logic of the tokenizer
// depends on htok_pkg
`timescale 1ns / 1ps
`default_nettype none

module htok_parser #(
  parameter int unsigned MaxHeaders = htok_pkg::MaxHeadersDef
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               step_i,
  input  wire  [7:0]        data_i,
  input  wire               eob_i,
  output logic              emit_o,
  output htok_pkg::result_t result_o
);
  import htok_pkg::*;

  localparam int unsigned CntW = $clog2(MaxHeaders + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(MaxHeaders);

  phase_e        phase_q, phase_d;
  logic [CntW-1:0] hdr_q, hdr_d;
  logic [2:0]    stat_q, stat_d;
  logic          start_q, start_d;

  logic          emit, valid, fend, is_cr, is_sp, is_colon;
  logic [2:0]    kind;
  phase_e        phase_n;
  logic [CntW-1:0] hdr_n;
  logic [2:0]    stat_n;
  logic          start_n;

  assign is_cr    = (data_i == ChCr);
  assign is_sp    = (data_i == ChSp);
  assign is_colon = (data_i == ChColon);

  // per-byte phase logic
  always_comb begin
    emit    = 1'b0;
    valid   = 1'b0;
    fend    = 1'b0;
    kind    = KindMethod;
    phase_n = phase_q;
    hdr_n   = hdr_q;
    stat_n  = stat_q;
    start_n = start_q;
    unique case (phase_q)
      PhMethod: begin
        emit    = 1'b1;
        start_n = 1'b0;
        if (is_cr && start_q) begin
          kind = KindDone; fend = 1'b1; phase_n = PhLfBody;
        end else if (is_cr) begin
          if (stat_q == StatOk) stat_n = StatNoSpace;
          fend = 1'b1; phase_n = PhLfLine;
        end else if (is_sp) begin
          fend = 1'b1; phase_n = PhPath;
        end else begin
          valid = 1'b1;
        end
      end
      PhPath: begin
        kind = KindPath; emit = 1'b1;
        if (is_cr) begin
          if (stat_q == StatOk) stat_n = StatNoSpace;
          fend = 1'b1; phase_n = PhLfLine;
        end else if (is_sp) begin
          fend = 1'b1; phase_n = PhVersion;
        end else begin
          valid = 1'b1;
        end
      end
      PhVersion: begin
        kind = KindVersion; emit = 1'b1;
        if (is_cr) begin
          fend = 1'b1; phase_n = PhLfLine;
        end else begin
          valid = 1'b1;
        end
      end
      PhLfLine: begin
        phase_n = PhName;
        start_n = 1'b1;
      end
      PhName: begin
        start_n = 1'b0;
        if (start_q && is_cr) begin
          kind = KindDone; emit = 1'b1; fend = 1'b1; phase_n = PhLfBody;
        end else if (start_q && hdr_q >= CntMax) begin
          if (stat_q == StatOk) stat_n = StatTooMany;
          phase_n = PhDiscard;
        end else begin
          kind = KindName; emit = 1'b1;
          if (is_colon) begin
            fend = 1'b1; phase_n = PhSkipSep;
          end else if (is_cr) begin
            if (stat_q == StatOk) stat_n = StatNoColon;
            fend = 1'b1; phase_n = PhLfLine;
          end else begin
            valid = 1'b1;
          end
        end
      end
      PhSkipSep: begin
        if (is_cr) begin
          kind = KindValue; emit = 1'b1; fend = 1'b1;
          hdr_n = hdr_q + 1'b1; phase_n = PhLfLine;
        end else begin
          phase_n = PhValue;
        end
      end
      PhValue: begin
        kind = KindValue; emit = 1'b1;
        if (is_cr) begin
          fend = 1'b1; hdr_n = hdr_q + 1'b1; phase_n = PhLfLine;
        end else begin
          valid = 1'b1;
        end
      end
      PhDiscard: begin
        if (is_cr) phase_n = PhLfLine;
      end
      PhLfBody: begin
        phase_n = PhBody;
      end
      default: begin
        kind = KindBody; emit = 1'b1; valid = 1'b1;
        phase_n = PhBody;
      end
    endcase

    // end of request: flag early end, close the field or emit a filler
    if (eob_i) begin
      if (phase_n != PhBody && phase_n != PhLfBody && stat_n == StatOk) begin
        stat_n = StatEarlyEnd;
      end
      if (emit) begin
        fend = 1'b1;
      end else begin
        emit = 1'b1; kind = KindMethod; valid = 1'b0; fend = 1'b0;
      end
    end
  end

  // result fields
  always_comb begin
    result_o.field_kind   = kind;
    result_o.out_byte     = valid ? data_i : 8'd0;
    result_o.byte_valid   = valid;
    result_o.field_end    = fend;
    result_o.header_index = 4'(hdr_q);
    result_o.header_total = 5'(hdr_n);
    result_o.parse_status = stat_n;
    result_o.request_end  = eob_i;
  end
  assign emit_o = emit;

  // next state, back to reset after the last byte
  always_comb begin
    phase_d = phase_q;
    hdr_d   = hdr_q;
    stat_d  = stat_q;
    start_d = start_q;
    if (step_i) begin
      if (eob_i) begin
        phase_d = PhMethod;
        hdr_d   = '0;
        stat_d  = StatOk;
        start_d = 1'b1;
      end else begin
        phase_d = phase_n;
        hdr_d   = hdr_n;
        stat_d  = stat_n;
        start_d = start_n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhMethod;
      hdr_q   <= '0;
      stat_q  <= StatOk;
      start_q <= 1'b1;
    end else begin
      phase_q <= phase_d;
      hdr_q   <= hdr_d;
      stat_q  <= stat_d;
      start_q <= start_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/htok_out_stage.sv
// result register of the tokenizer
// depends on htok_pkg and htok_out_if
`timescale 1ns / 1ps
`default_nettype none

module htok_out_stage (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               load_i,
  input  wire htok_pkg::result_t result_i,
  output logic              free_o,
  htok_out_if.source        out_o
);
  import htok_pkg::*;

  logic    valid_q;
  result_t res_q;

  // slot can be written when empty or drained this cycle
  assign free_o = !valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (free_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (free_o && load_i) begin
      res_q <= result_i;
    end
  end

  assign out_o.valid        = valid_q;
  assign out_o.field_kind   = res_q.field_kind;
  assign out_o.out_byte     = res_q.out_byte;
  assign out_o.byte_valid   = res_q.byte_valid;
  assign out_o.field_end    = res_q.field_end;
  assign out_o.header_index = res_q.header_index;
  assign out_o.header_total = res_q.header_total;
  assign out_o.parse_status = res_q.parse_status;
  assign out_o.request_end  = res_q.request_end;

endmodule

`default_nettype wire

FILE: rtl/core/http_request_tokenizer.sv
// channel  dir  modport  payload
// in_i     in   sink     data_byte[8], end_of_buffer[1]
// out_o    out  source   field_kind[3], out_byte[8], byte_valid, field_end,
//                        header_index[4], header_total[5], parse_status[3], request_end
//
// one byte per cycle sustained while out_o is not stalled; a byte is held in the input register and
// its result is loaded into the result register when the parser steps on it, and is then on out_o.
// bytes that give no result (lf, skipped separator, dropped header) load nothing into the result register.
// reset (rst_ni low, asynchronous) returns the parser to the start of a request.
// a stalled output holds the parser and the input register, so in_i.ready drops.
// top level of the http request tokenizer; depends on htok_pkg, htok_in_if, htok_out_if,
// htok_in_stage, htok_parser and htok_out_stage
`timescale 1ns / 1ps
`default_nettype none

module http_request_tokenizer #(
  parameter int unsigned MaxHeaders = htok_pkg::MaxHeadersDef
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  htok_in_if.sink    in_i,
  htok_out_if.source out_o
);
  import htok_pkg::*;

  logic       s1_valid, s1_eob, step, emit, out_free;
  logic [7:0] s1_data;
  result_t    result;

  // held byte is parsed once the result slot can take it
  assign step = s1_valid && out_free;

  htok_in_stage u_in (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .advance_i (step),
    .valid_o   (s1_valid),
    .data_o    (s1_data),
    .eob_o     (s1_eob)
  );

  htok_parser #(.MaxHeaders(MaxHeaders)) u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .data_i   (s1_data),
    .eob_i    (s1_eob),
    .emit_o   (emit),
    .result_o (result)
  );

  htok_out_stage u_out (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (step && emit),
    .result_i (result),
    .free_o   (out_free),
    .out_o    (out_o)
  );

endmodule

`default_nettype wire
